>>> design/acms_pkg.sv
// Shared types, constants and the microcode table of the ADC matrix scan sequencer.
package acms_pkg;

  // Grid size
  localparam int ROW_COUNT    = 16;
  localparam int COLUMN_COUNT = 8;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int SAMPLE_W  = 12;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 4;
  localparam int SETTLE_W  = 16;
  localparam int DUMMY_W   = 4;
  localparam int SUM_W     = 16;
  localparam int PC_W      = 6;

  localparam logic [INDEX_W-1:0]  LAST_ROW            = INDEX_W'(ROW_COUNT - 1);
  localparam logic [INDEX_W-1:0]  LAST_COLUMN         = INDEX_W'(COLUMN_COUNT - 1);
  localparam logic [INDEX_W-1:0]  SECOND_DUMMY_COLUMN = 4'd7;
  localparam logic [DUMMY_W-1:0]  DUMMY_LIMIT         = 4'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX          = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_SETTLE_CYCLES     = 2'd0;
  localparam logic [1:0] REG_DUMMY_READS       = 2'd1;
  localparam logic [1:0] REG_OVERSAMPLE_ENABLE = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    A_START = 2'd0,
    A_TICK  = 2'd1,
    A_CONV  = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    K_SELECT  = 2'd0,
    K_CONVERT = 2'd1,
    K_CELL    = 2'd2,
    K_DONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_DUMMY,
    PH_CONVERT
  } phase_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_START_IDLE,
    C_TICK_SETTLE,
    C_CONV_DUMMY,
    C_CONV_CONVERT,
    C_SETTLE_ZERO,
    C_SETTLE_DONE,
    C_NO_DUMMY,
    C_SECOND,
    C_DUMMY_DONE,
    C_MORE_READS,
    C_LAST_COL,
    C_LAST_ROW
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ROW_ZERO,
    OP_SETTLE_CLEAR,
    OP_PHASE_SETTLE,
    OP_SETTLE_INC,
    OP_COL_ZERO,
    OP_DUMMY_BEGIN,
    OP_CELL_BEGIN,
    OP_SECOND_SET,
    OP_SECOND_NEXT,
    OP_ACCUM,
    OP_DIV_START,
    OP_COL_INC,
    OP_ROW_INC,
    OP_SCAN_END
  } op_t;

  // Result emitted by a step
  typedef enum logic [2:0] {
    E_NONE,
    E_SELECT,
    E_CONV_COL,
    E_DUMMY_FIRST,
    E_DUMMY_SECOND,
    E_CELL,
    E_DONE
  } emit_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    op_t             op;
    emit_t           emit;
    logic            fetch;     // wait for and take an input word
    logic            fin;       // flush the held result marked last, then return
    logic            wait_div;  // hold while the divider runs
  } uword_t;

  typedef struct packed {
    logic stall;
    logic take;
  } seq_status_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_cycles;
    logic [DUMMY_W-1:0]  dummy_reads;
    logic                oversample_enable;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  row_index;
    logic [INDEX_W-1:0]  column_index;
    logic                discard;
    logic [SAMPLE_W-1:0] cell_value;
  } result_t;

  // Program labels
  localparam logic [PC_W-1:0] L_FETCH      = 6'd0;
  localparam logic [PC_W-1:0] L_START      = 6'd6;
  localparam logic [PC_W-1:0] L_BEGIN_ROW  = 6'd7;
  localparam logic [PC_W-1:0] L_TICK       = 6'd10;
  localparam logic [PC_W-1:0] L_BEGIN_CONV = 6'd13;
  localparam logic [PC_W-1:0] L_REQ_CELL   = 6'd17;
  localparam logic [PC_W-1:0] L_DUMMY      = 6'd19;
  localparam logic [PC_W-1:0] L_DUMMY_NEXT = 6'd22;
  localparam logic [PC_W-1:0] L_CONV       = 6'd26;
  localparam logic [PC_W-1:0] L_ROW_END    = 6'd33;
  localparam logic [PC_W-1:0] L_SCAN_END   = 6'd36;
  localparam logic [PC_W-1:0] L_MORE_READS = 6'd38;

  function automatic uword_t mk(input cond_t c, input logic [PC_W-1:0] t, input op_t o,
                                input emit_t e, input logic f, input logic n,
                                input logic w);
    uword_t u;
    u.cond     = c;
    u.target   = t;
    u.op       = o;
    u.emit     = e;
    u.fetch    = f;
    u.fin      = n;
    u.wait_div = w;
    return u;
  endfunction

  // Microcode table
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      6'd0:  u = mk(C_NEVER,        L_FETCH,      OP_NONE,         E_NONE,         1'b1, 1'b0, 1'b0);
      6'd1:  u = mk(C_START_IDLE,   L_START,      OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd2:  u = mk(C_TICK_SETTLE,  L_TICK,       OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd3:  u = mk(C_CONV_DUMMY,   L_DUMMY,      OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd4:  u = mk(C_CONV_CONVERT, L_CONV,       OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd5:  u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd6:  u = mk(C_NEVER,        L_FETCH,      OP_ROW_ZERO,     E_NONE,         1'b0, 1'b0, 1'b0);
      6'd7:  u = mk(C_NEVER,        L_FETCH,      OP_SETTLE_CLEAR, E_SELECT,       1'b0, 1'b0, 1'b0);
      6'd8:  u = mk(C_SETTLE_ZERO,  L_BEGIN_CONV, OP_PHASE_SETTLE, E_NONE,         1'b0, 1'b0, 1'b0);
      6'd9:  u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd10: u = mk(C_NEVER,        L_FETCH,      OP_SETTLE_INC,   E_NONE,         1'b0, 1'b0, 1'b0);
      6'd11: u = mk(C_SETTLE_DONE,  L_BEGIN_CONV, OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd12: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd13: u = mk(C_NEVER,        L_FETCH,      OP_COL_ZERO,     E_NONE,         1'b0, 1'b0, 1'b0);
      6'd14: u = mk(C_NO_DUMMY,     L_REQ_CELL,   OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd15: u = mk(C_NEVER,        L_FETCH,      OP_DUMMY_BEGIN,  E_DUMMY_FIRST,  1'b0, 1'b0, 1'b0);
      6'd16: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd17: u = mk(C_NEVER,        L_FETCH,      OP_CELL_BEGIN,   E_CONV_COL,     1'b0, 1'b0, 1'b0);
      6'd18: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd19: u = mk(C_SECOND,       L_DUMMY_NEXT, OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd20: u = mk(C_NEVER,        L_FETCH,      OP_SECOND_SET,   E_DUMMY_SECOND, 1'b0, 1'b0, 1'b0);
      6'd21: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd22: u = mk(C_NEVER,        L_FETCH,      OP_SECOND_NEXT,  E_NONE,         1'b0, 1'b0, 1'b0);
      6'd23: u = mk(C_DUMMY_DONE,   L_REQ_CELL,   OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd24: u = mk(C_NEVER,        L_FETCH,      OP_NONE,         E_DUMMY_FIRST,  1'b0, 1'b0, 1'b0);
      6'd25: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd26: u = mk(C_NEVER,        L_FETCH,      OP_ACCUM,        E_NONE,         1'b0, 1'b0, 1'b0);
      6'd27: u = mk(C_MORE_READS,   L_MORE_READS, OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd28: u = mk(C_NEVER,        L_FETCH,      OP_DIV_START,    E_NONE,         1'b0, 1'b0, 1'b0);
      6'd29: u = mk(C_NEVER,        L_FETCH,      OP_NONE,         E_CELL,         1'b0, 1'b0, 1'b1);
      6'd30: u = mk(C_LAST_COL,     L_ROW_END,    OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd31: u = mk(C_NEVER,        L_FETCH,      OP_COL_INC,      E_NONE,         1'b0, 1'b0, 1'b0);
      6'd32: u = mk(C_ALWAYS,       L_REQ_CELL,   OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd33: u = mk(C_LAST_ROW,     L_SCAN_END,   OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd34: u = mk(C_NEVER,        L_FETCH,      OP_ROW_INC,      E_NONE,         1'b0, 1'b0, 1'b0);
      6'd35: u = mk(C_ALWAYS,       L_BEGIN_ROW,  OP_NONE,         E_NONE,         1'b0, 1'b0, 1'b0);
      6'd36: u = mk(C_NEVER,        L_FETCH,      OP_SCAN_END,     E_DONE,         1'b0, 1'b0, 1'b0);
      6'd37: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      6'd38: u = mk(C_NEVER,        L_FETCH,      OP_NONE,         E_CONV_COL,     1'b0, 1'b0, 1'b0);
      6'd39: u = mk(C_ALWAYS,       L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
      default: u = mk(C_ALWAYS,     L_FETCH,      OP_NONE,         E_NONE,         1'b0, 1'b1, 1'b0);
    endcase
    return u;
  endfunction

endpackage

>>> design/acms_div.sv
// Restoring divider, one quotient bit per cycle, for the oversampled cell average.
module acms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [acms_pkg::SUM_W-1:0]    dividend,
  input  logic [acms_pkg::DUMMY_W-1:0]  divisor,
  output logic                          busy,
  output logic [acms_pkg::SUM_W-1:0]    quotient
);
  import acms_pkg::*;

  localparam int COUNT_W = $clog2(SUM_W + 1);

  logic [COUNT_W-1:0] count;
  logic [DUMMY_W-1:0] rem;
  logic [DUMMY_W-1:0] dsor;
  logic [DUMMY_W:0]   trial;
  logic               fits;

  // Shift in the next dividend bit and try the divisor
  assign trial = {rem, quotient[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= COUNT_W'(SUM_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (count != '0) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? DUMMY_W'(trial - {1'b0, dsor}) : trial[DUMMY_W-1:0];
    end
  end

  assign busy = count != '0;

endmodule

>>> design/acms_ctrl.sv
// Step counter and microcode fetch with conditional jumps.
module acms_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  acms_pkg::seq_status_t status,
  output acms_pkg::uword_t      uword
);
  import acms_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;

  assign uword = ucode(pc);

  // Hold on a stall, jump when the condition holds, else step on
  always_comb begin
    if (status.stall) begin
      pc_next = pc;
    end else if (status.take) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> design/acms_datapath.sv
// Scan state, condition evaluation, result holding register and output register.
module acms_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  acms_pkg::cfg_t                cfg,
  input  acms_pkg::uword_t              uword,
  output acms_pkg::seq_status_t         status,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [acms_pkg::ACTION_W-1:0] s_action,
  input  logic [acms_pkg::SAMPLE_W-1:0] s_sample,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output acms_pkg::result_t             m_result,
  output logic                          m_last
);
  import acms_pkg::*;

  action_t             action;
  logic [SAMPLE_W-1:0] sample;
  phase_t              phase;
  logic [INDEX_W-1:0]  current_row;
  logic [INDEX_W-1:0]  current_column;
  logic [SETTLE_W-1:0] settle_count;
  logic [DUMMY_W-1:0]  dummy_count;
  logic                dummy_second;
  logic [DUMMY_W-1:0]  read_count;
  logic [SUM_W-1:0]    sample_sum;

  result_t             pend;
  logic                pend_valid;
  result_t             new_result;

  logic                slot_free;
  logic                push;
  logic                go;
  logic                cond_true;
  logic                use_avg;
  logic                div_start;
  logic                div_busy;
  logic [SUM_W-1:0]    quotient;

  acms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample_sum),
    .divisor  (read_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign use_avg   = cfg.oversample_enable && (read_count != '0);
  assign slot_free = !m_tvalid || m_tready;
  assign push      = ((uword.emit != E_NONE) || uword.fin) && pend_valid;
  assign s_tready  = uword.fetch;

  // Stall on a missing input word, a full output register or a running divide
  assign go = !((uword.fetch && !s_tvalid) || (push && !slot_free)
                || (uword.wait_div && div_busy));

  assign div_start    = go && (uword.op == OP_DIV_START) && use_avg;
  assign status.stall = !go;
  assign status.take  = cond_true;

  // Evaluate the jump condition
  always_comb begin
    case (uword.cond)
      C_NEVER:        cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_START_IDLE:   cond_true = (action == A_START) && (phase == PH_IDLE);
      C_TICK_SETTLE:  cond_true = (action == A_TICK) && (phase == PH_SETTLE);
      C_CONV_DUMMY:   cond_true = (action == A_CONV) && (phase == PH_DUMMY);
      C_CONV_CONVERT: cond_true = (action == A_CONV) && (phase == PH_CONVERT);
      C_SETTLE_ZERO:  cond_true = cfg.settle_cycles == '0;
      C_SETTLE_DONE:  cond_true = settle_count >= cfg.settle_cycles;
      C_NO_DUMMY:     cond_true = cfg.oversample_enable || (cfg.dummy_reads == '0);
      C_SECOND:       cond_true = dummy_second;
      C_DUMMY_DONE:   cond_true = dummy_count >= cfg.dummy_reads;
      C_MORE_READS:   cond_true = cfg.oversample_enable
                                  && ({1'b0, read_count} < ({1'b0, cfg.dummy_reads} + 1'b1));
      C_LAST_COL:     cond_true = current_column == LAST_COLUMN;
      C_LAST_ROW:     cond_true = current_row == LAST_ROW;
      default:        cond_true = 1'b0;
    endcase
  end

  // Build the result that this step emits
  always_comb begin
    new_result              = '0;
    new_result.row_index    = current_row;
    case (uword.emit)
      E_SELECT: begin
        new_result.kind = K_SELECT;
      end
      E_CONV_COL: begin
        new_result.kind         = K_CONVERT;
        new_result.column_index = current_column;
      end
      E_DUMMY_FIRST: begin
        new_result.kind    = K_CONVERT;
        new_result.discard = 1'b1;
      end
      E_DUMMY_SECOND: begin
        new_result.kind         = K_CONVERT;
        new_result.column_index = SECOND_DUMMY_COLUMN;
        new_result.discard      = 1'b1;
      end
      E_CELL: begin
        new_result.kind         = K_CELL;
        new_result.column_index = current_column;
        new_result.cell_value   = use_avg ? quotient[SAMPLE_W-1:0] : sample;
      end
      E_DONE: begin
        new_result.kind      = K_DONE;
        new_result.row_index = '0;
      end
      default: begin
        new_result = '0;
      end
    endcase
  end

  // Latch the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      action <= A_START;
    end else if (go && uword.fetch) begin
      action <= action_t'(s_action);
    end
  end

  always_ff @(posedge clk) begin
    if (go && uword.fetch) begin
      sample <= s_sample;
    end
  end

  // Apply the step's operation to the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      current_row    <= '0;
      current_column <= '0;
      settle_count   <= '0;
      dummy_count    <= '0;
      dummy_second   <= 1'b0;
      read_count     <= '0;
      sample_sum     <= '0;
    end else if (go) begin
      case (uword.op)
        OP_ROW_ZERO:     current_row <= '0;
        OP_SETTLE_CLEAR: settle_count <= '0;
        OP_PHASE_SETTLE: phase <= PH_SETTLE;
        OP_SETTLE_INC: begin
          if (settle_count != SETTLE_MAX) begin
            settle_count <= settle_count + 1'b1;
          end
        end
        OP_COL_ZERO:     current_column <= '0;
        OP_DUMMY_BEGIN: begin
          phase        <= PH_DUMMY;
          dummy_count  <= '0;
          dummy_second <= 1'b0;
        end
        OP_CELL_BEGIN: begin
          phase      <= PH_CONVERT;
          read_count <= '0;
          sample_sum <= '0;
        end
        OP_SECOND_SET:   dummy_second <= 1'b1;
        OP_SECOND_NEXT: begin
          dummy_second <= 1'b0;
          dummy_count  <= dummy_count + 1'b1;
        end
        OP_ACCUM: begin
          sample_sum <= sample_sum + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
          read_count <= read_count + 1'b1;
        end
        OP_COL_INC:      current_column <= current_column + 1'b1;
        OP_ROW_INC: begin
          current_column <= '0;
          current_row    <= current_row + 1'b1;
        end
        OP_SCAN_END: begin
          current_column <= '0;
          current_row    <= '0;
          phase          <= PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the newest result until the next one or the end of the word shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (go) begin
      if (uword.emit != E_NONE) begin
        pend_valid <= 1'b1;
      end else if (uword.fin) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && (uword.emit != E_NONE)) begin
      pend <= new_result;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && push) begin
      m_result <= pend;
      m_last   <= uword.fin;
    end
  end

endmodule

>>> design/adc_matrix_scan_sequencer_core.sv
// Top level of the ADC matrix scan sequencer: configuration registers and stream ports.
//
//  channel  | direction | handshake         | contents
//  ---------+-----------+-------------------+---------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | tuser: action; tdata: sample
//  m_*      | out       | m_tvalid/m_tready | tuser: kind, discard; tdata: row, column,
//           |           |                   | cell value; tlast: last result of the word
//  cfg_*    | in        | cfg_we            | settle_cycles, dummy_reads, oversample_enable
//
// One input word at a time runs through a 40-step microcode program, and through the
// one-bit-per-cycle divider when an oversampled cell is averaged. Each result costs one
// step; a result waits in a holding register until the next one or the end of the word
// shows whether it is last. A full output register stalls the step counter.
// Synchronous reset returns the program to its fetch step with the scan idle.
module adc_matrix_scan_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] unused
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] row_index, [7:4] column_index, [19:8] cell_value,
                                 // [23:20] zero
  output logic [2:0]  m_tuser,   // [1:0] kind, [2] discard
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import acms_pkg::*;

  cfg_t        cfg;
  uword_t      uword;
  seq_status_t status;
  result_t     m_result;

  // Configuration registers; a dummy read count whose low four bits exceed DUMMY_LIMIT is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETTLE_CYCLES:     cfg.settle_cycles <= cfg_wdata;
        REG_DUMMY_READS: begin
          if (cfg_wdata[DUMMY_W-1:0] <= DUMMY_LIMIT) begin
            cfg.dummy_reads <= cfg_wdata[DUMMY_W-1:0];
          end
        end
        REG_OVERSAMPLE_ENABLE: cfg.oversample_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  acms_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  acms_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .uword    (uword),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_action (s_tuser),
    .s_sample (s_tdata[SAMPLE_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result),
    .m_last   (m_tlast)
  );

  // Pack the result word
  assign m_tdata = {4'b0000, m_result.cell_value, m_result.column_index, m_result.row_index};
  assign m_tuser = {m_result.discard, m_result.kind};

endmodule
